// ===== hw/rtl/lrlcf_pkg.sv =====
// ----------------------------------------------------------------------------
// lrlcf_pkg
// Types, limits and lookup tables of the RGB lamp command filter.
// ----------------------------------------------------------------------------
`default_nettype none

package lrlcf_pkg;

    localparam int unsigned PRESET_COUNT  = 20;
    localparam int unsigned ADDRESS_SLOTS = 15;

    localparam logic [7:0] MAX_FADE      = 8'd250;
    localparam logic [7:0] MAX_INTENSITY = 8'd100;
    localparam logic [7:0] PRESET_LAST   = 8'(PRESET_COUNT - 1);

    localparam logic CMD_FRAME = 1'b0;
    localparam logic CMD_SLEEP = 1'b1;

    localparam logic [7:0] ADDR_TABLE [ADDRESS_SLOTS] = '{
        8'h21, 8'h02, 8'h13, 8'h04, 8'h05,
        8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
        8'h01, 8'h0C, 8'h03, 8'h11, 8'h12
    };

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] inten;
        logic [7:0] fade;
        logic       led;
        logic       custom;
        logic       fading;
    } t_frame;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [6:0] inten;
        logic [7:0] ramp;
        logic [4:0] preset;
        logic       led;
        logic       custom;
        logic       fading;
    } t_lamp;

    typedef struct packed {
        logic   accept;
        t_lamp  lamp;
        t_frame saved;
    } t_decision;

    function automatic logic group_hit(input logic [7:0] addr, input logic [15:0] mask);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < ADDRESS_SLOTS; i++) begin
            if (ADDR_TABLE[i] == addr && mask[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [23:0] preset_color(input logic [4:0] idx);
        logic [23:0] rgb;
        case (idx)
            5'd0:    rgb = 24'hFF3D3D;
            5'd1:    rgb = 24'hFF433D;
            5'd2:    rgb = 24'hFF773D;
            5'd3:    rgb = 24'hFFAA47;
            5'd4:    rgb = 24'hFFEB61;
            5'd5:    rgb = 24'hF4F4E9;
            5'd6:    rgb = 24'h93FF7E;
            5'd7:    rgb = 24'h2DFF5E;
            5'd8:    rgb = 24'h2DFF9D;
            5'd9:    rgb = 24'h2DFFFF;
            5'd10:   rgb = 24'h2DD5FF;
            5'd11:   rgb = 24'h1FB9FF;
            5'd12:   rgb = 24'h1F90FF;
            5'd13:   rgb = 24'h0B6EFF;
            5'd14:   rgb = 24'h0B36FF;
            5'd15:   rgb = 24'h4F0BFF;
            5'd16:   rgb = 24'h7E0BFF;
            5'd17:   rgb = 24'hB16CFF;
            5'd18:   rgb = 24'hFFA9CC;
            default: rgb = 24'hFF267D;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lrlcf_decode.sv =====
// ----------------------------------------------------------------------------
// lrlcf_decode
// Frame qualification and next lamp / saved-frame state for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module lrlcf_decode (
    input  wire logic                 i_command,
    input  wire logic [15:0]          i_group_mask,
    input  wire lrlcf_pkg::t_frame    i_frame,
    input  wire logic [7:0]           i_single_address,
    input  wire lrlcf_pkg::t_frame    i_saved,
    input  wire lrlcf_pkg::t_lamp     i_lamp,
    output lrlcf_pkg::t_decision      o_decision
);

    logic        addr_ok;
    logic        range_ok;
    logic        changed;
    logic [23:0] rgb;

    assign addr_ok  = lrlcf_pkg::group_hit(i_single_address, i_group_mask);
    assign range_ok = (i_frame.fade <= lrlcf_pkg::MAX_FADE)
                   && (i_frame.inten <= lrlcf_pkg::MAX_INTENSITY)
                   && (i_frame.custom || i_frame.red <= lrlcf_pkg::PRESET_LAST);
    assign changed  = (i_frame != i_saved);
    assign rgb      = lrlcf_pkg::preset_color(i_frame.red[4:0]);

    always_comb begin
        o_decision.accept = 1'b0;
        o_decision.lamp   = i_lamp;
        o_decision.saved  = i_saved;
        if (i_command == lrlcf_pkg::CMD_SLEEP) begin
            o_decision.saved.red   = '0;
            o_decision.saved.green = '0;
            o_decision.saved.blue  = '0;
            o_decision.saved.inten = '0;
            o_decision.saved.fade  = '0;
        end else if (addr_ok && range_ok && changed) begin
            o_decision.accept      = 1'b1;
            o_decision.saved       = i_frame;
            o_decision.lamp.led    = i_frame.led;
            o_decision.lamp.custom = i_frame.custom;
            o_decision.lamp.fading = i_frame.fading;
            o_decision.lamp.ramp   = i_frame.fading ? i_frame.fade : 8'd0;
            if (!i_frame.led) begin
                o_decision.lamp.red   = '0;
                o_decision.lamp.green = '0;
                o_decision.lamp.blue  = '0;
                o_decision.lamp.inten = '0;
            end else if (i_frame.custom) begin
                o_decision.lamp.red   = i_frame.red;
                o_decision.lamp.green = i_frame.green;
                o_decision.lamp.blue  = i_frame.blue;
                o_decision.lamp.inten = i_frame.inten[6:0];
            end else begin
                o_decision.lamp.preset = i_frame.red[4:0];
                o_decision.lamp.red    = rgb[23:16];
                o_decision.lamp.green  = rgb[15:8];
                o_decision.lamp.blue   = rgb[7:0];
                o_decision.lamp.inten  = i_frame.inten[6:0];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/lin_rgb_lamp_command_filter_core.sv =====
// ----------------------------------------------------------------------------
// lin_rgb_lamp_command_filter_core
// Filters decoded lamp-control frames and sleep events and holds lamp state.
// ----------------------------------------------------------------------------
// The result is registered and becomes valid in the cycle after the input transfer.
// Throughput: 1 item per cycle; the result register drains while the next
//   item is taken, so input stalls only while a held result is stalled.
// Reset (synchronous, active low): lamp state, saved frame and address clear
//   to zero, no result pending.
`default_nettype none

module lin_rgb_lamp_command_filter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [7:0]  i_cfg_wr_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_command,
    input  wire logic [15:0] i_group_mask,
    input  wire logic [7:0]  i_red_or_preset,
    input  wire logic [7:0]  i_green_value,
    input  wire logic [7:0]  i_blue_value,
    input  wire logic [7:0]  i_intensity_value,
    input  wire logic [7:0]  i_fading_time,
    input  wire logic        i_led_enable,
    input  wire logic        i_custom_color_mode,
    input  wire logic        i_fading_enable,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_new_signal,
    output logic [7:0]       o_red_out,
    output logic [7:0]       o_green_out,
    output logic [7:0]       o_blue_out,
    output logic [6:0]       o_intensity_out,
    output logic [7:0]       o_ramp_out,
    output logic [4:0]       o_preset_out,
    output logic             o_led_on_out,
    output logic             o_custom_mode_out,
    output logic             o_fading_on_out
);

    logic [7:0]            r_single_address;
    lrlcf_pkg::t_frame     r_saved;
    lrlcf_pkg::t_lamp      r_lamp;
    logic                  r_new_signal;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic                  in_xfer;
    lrlcf_pkg::t_frame     frame;
    lrlcf_pkg::t_decision  decision;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign frame.red    = i_red_or_preset;
    assign frame.green  = i_green_value;
    assign frame.blue   = i_blue_value;
    assign frame.inten  = i_intensity_value;
    assign frame.fade   = i_fading_time;
    assign frame.led    = i_led_enable;
    assign frame.custom = i_custom_color_mode;
    assign frame.fading = i_fading_enable;

    lrlcf_decode u_decode (
        .i_command        (i_command),
        .i_group_mask     (i_group_mask),
        .i_frame          (frame),
        .i_single_address (r_single_address),
        .i_saved          (r_saved),
        .i_lamp           (r_lamp),
        .o_decision       (decision)
    );

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (in_xfer) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single_address <= '0;
            r_saved          <= '0;
            r_lamp           <= '0;
            r_new_signal     <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_single_address <= i_cfg_wr_data;
            end
            if (in_xfer) begin
                r_saved      <= decision.saved;
                r_lamp       <= decision.lamp;
                r_new_signal <= decision.accept;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_new_signal      = r_new_signal;
    assign o_red_out         = r_lamp.red;
    assign o_green_out       = r_lamp.green;
    assign o_blue_out        = r_lamp.blue;
    assign o_intensity_out   = r_lamp.inten;
    assign o_ramp_out        = r_lamp.ramp;
    assign o_preset_out      = r_lamp.preset;
    assign o_led_on_out      = r_lamp.led;
    assign o_custom_mode_out = r_lamp.custom;
    assign o_fading_on_out   = r_lamp.fading;

    a_xfer_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_out_valid)
        else $error("input transfer without result");

    a_lamp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lamp.inten <= 7'd100 && r_lamp.ramp <= 8'd250 && r_lamp.preset <= 5'd19)
        else $error("lamp state out of range");

    a_led_off_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_new_signal && !r_lamp.led)
            |-> (r_lamp.red == 8'd0 && r_lamp.green == 8'd0
                 && r_lamp.blue == 8'd0 && r_lamp.inten == 7'd0))
        else $error("disabled LED shows color");

    a_sleep_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_command == lrlcf_pkg::CMD_SLEEP) |=> (!r_new_signal && $stable(r_lamp)))
        else $error("sleep event changed lamp state");

endmodule

`default_nettype wire
